/* hdl/pmx_pkg.sv */
// ----------------------------------------------------------------------------
// PMX package
// Shared types and constants of the partially mapped crossover block.
// ----------------------------------------------------------------------------
package pmx_pkg;

	localparam int GENE_W          = 6;
	localparam int GENE_SPACE      = 64;
	localparam int MAX_GENES_DEF   = 64;
	localparam int CUT_START_W     = 6;
	localparam int CUT_END_W       = 7;

	typedef logic [GENE_W-1:0] gene_t;

	typedef struct packed {
		gene_t                  gene_a;
		gene_t                  gene_b;
		logic [CUT_START_W-1:0] cut_start;
		logic [CUT_END_W-1:0]   cut_end;
		logic                   last;
	} pmx_req_t;

	typedef struct packed {
		gene_t child_a_gene;
		gene_t child_b_gene;
		logic  final_res;
	} pmx_res_t;

	// Status from the sequencer to the top level.
	typedef struct packed {
		logic  busy;
		logic  emit;
		logic  last;
		gene_t gene_a;
		gene_t gene_b;
	} pmx_stat_t;

endpackage

/* hdl/partially_mapped_crossover.sv */
// ----------------------------------------------------------------------------
// Partially mapped crossover
// Loads two parent permutations and streams the two PMX children.
// ----------------------------------------------------------------------------
// A request carries one position of both parents and is taken whenever start
// is high and busy is low; loading runs at one request per cycle. The request
// marked last closes the block and supplies the cut points. The block then
// raises busy and builds the two children one after the other on a single
// sequencer with one read port per memory. Per child it fills the position
// map, copies the segment, runs one mapping walk for each segment position
// of the other parent whose gene is not yet placed, taking mapping steps
// until it leaves the segment, and then finishes the child. The N results
// then leave back to back, each shown for exactly one cycle with res_stb
// high; the receiver cannot stall them, so it must take every result as it
// comes. Busy falls in the cycle after the last result is presented, and a
// new block may start loading at once.
// ----------------------------------------------------------------------------
module partially_mapped_crossover #(
	parameter int MAX_GENES = pmx_pkg::MAX_GENES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pmx_pkg::pmx_req_t req,
	output logic              res_stb,
	output pmx_pkg::pmx_res_t res
);
	import pmx_pkg::*;

	localparam int PW = $clog2(MAX_GENES);
	localparam int CW = $clog2(MAX_GENES + 1);
	// Width wide enough for both the raw cut points and the gene count.
	localparam int NW = (CW > CUT_END_W) ? CW : CUT_END_W;

	logic [CW-1:0] cnt_q;
	logic          go_q;
	logic [CW-1:0] n_q, s_q, e_q;
	logic          accept, room;
	logic [CW-1:0] n_new;
	logic [NW-1:0] sx, ex, lo, hi, nx;
	pmx_stat_t     stat;

	assign accept = start && !busy;
	assign room   = cnt_q < CW'(MAX_GENES);
	assign n_new  = room ? CW'(cnt_q + 1'b1) : cnt_q;

	// Order the cut points, then clamp both to the gene count.
	assign sx = NW'(req.cut_start);
	assign ex = NW'(req.cut_end);
	assign nx = NW'(n_new);
	assign lo = (sx > ex) ? ex : sx;
	assign hi = (sx > ex) ? sx : ex;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			go_q  <= 1'b0;
		end else begin
			go_q <= accept && req.last;
			if (accept) begin
				cnt_q <= req.last ? '0 : n_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.last) begin
			n_q <= n_new;
			s_q <= (lo > nx) ? n_new : CW'(lo);
			e_q <= (hi > nx) ? n_new : CW'(hi);
		end
	end

	pmx_ctrl #(.MAX_GENES(MAX_GENES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go_q),
		.n         (n_q),
		.seg_s     (s_q),
		.seg_e     (e_q),
		.ld_we     (accept && room),
		.ld_addr   (cnt_q[PW-1:0]),
		.ld_gene_a (req.gene_a),
		.ld_gene_b (req.gene_b),
		.stat      (stat)
	);

	assign busy = go_q || stat.busy;

	// Output register: results are registered from the child memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stb <= 1'b0;
		end else begin
			res_stb <= stat.emit;
		end
	end

	always_ff @(posedge clk) begin
		res.child_a_gene <= stat.gene_a;
		res.child_b_gene <= stat.gene_b;
		res.final_res    <= stat.last;
	end

endmodule

/* hdl/pmx_ram.sv */
// ----------------------------------------------------------------------------
// PMX generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pmx_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/pmx_ctrl.sv */
// ----------------------------------------------------------------------------
// PMX sequencer
// Holds the parent, child and position memories and steps one child at a
// time through fill, segment copy and mapping walks, then streams results.
// ----------------------------------------------------------------------------
module pmx_ctrl #(
	parameter int MAX_GENES = pmx_pkg::MAX_GENES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [$clog2(MAX_GENES+1)-1:0] n,
	input  logic [$clog2(MAX_GENES+1)-1:0] seg_s,
	input  logic [$clog2(MAX_GENES+1)-1:0] seg_e,
	input  logic                           ld_we,
	input  logic [$clog2(MAX_GENES)-1:0]   ld_addr,
	input  pmx_pkg::gene_t                 ld_gene_a,
	input  pmx_pkg::gene_t                 ld_gene_b,
	output pmx_pkg::pmx_stat_t             stat
);
	import pmx_pkg::*;

	localparam int PW = $clog2(MAX_GENES);
	localparam int CW = $clog2(MAX_GENES + 1);
	localparam int GA = $clog2(GENE_SPACE);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_FILL  = 9'b000000010,
		S_SEG   = 9'b000000100,
		S_WRD   = 9'b000001000,
		S_WG    = 9'b000010000,
		S_WTEST = 9'b000100000,
		S_WK    = 9'b001000000,
		S_WP    = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t                state_q;
	logic                  sel_q;
	logic [CW-1:0]         i_q;
	logic [PW-1:0]         idx_q;
	logic [CW-1:0]         steps_q;
	gene_t                 g_q;
	logic [GENE_SPACE-1:0] placed_q;
	logic [GENE_SPACE-1:0] posv_q;
	logic                  posv_bit_q;
	logic                  pend_s1;
	logic [PW-1:0]         idx_s1;
	logic                  last_s1;

	logic [PW-1:0] k_addr, o_addr, p1_raddr, p2_raddr, c_raddr, c_waddr;
	gene_t         p1_rd, p2_rd, k_rd, o_rd, c1_rd, c2_rd, c_wdata;
	logic          c_we, pos_we;
	logic [GA-1:0] pos_waddr, pos_raddr;
	logic [PW-1:0] pos_wdata, pos_rd;
	logic          rd_en, in_seg, walk_go;
	logic [CW-1:0] i_inc;

	assign i_inc    = CW'(i_q + 1'b1);
	assign k_rd     = sel_q ? p2_rd : p1_rd;
	assign o_rd     = sel_q ? p1_rd : p2_rd;
	assign p1_raddr = sel_q ? o_addr : k_addr;
	assign p2_raddr = sel_q ? k_addr : o_addr;
	assign in_seg   = (CW'(idx_q) >= seg_s) && (CW'(idx_q) < seg_e);
	assign walk_go  = in_seg && (steps_q < n);

	always_comb begin
		k_addr    = '0;
		o_addr    = '0;
		c_raddr   = i_q[PW-1:0];
		c_we      = 1'b0;
		c_waddr   = idx_s1;
		c_wdata   = o_rd;
		pos_we    = 1'b0;
		pos_waddr = o_rd;
		pos_wdata = idx_s1;
		pos_raddr = k_rd;
		rd_en     = 1'b0;
		case (state_q)
			S_FILL: begin
				rd_en  = i_q < n;
				o_addr = i_q[PW-1:0];
				c_we   = pend_s1;
				pos_we = pend_s1;
			end
			S_SEG: begin
				rd_en   = i_q < seg_e;
				k_addr  = i_q[PW-1:0];
				c_we    = pend_s1;
				c_wdata = k_rd;
			end
			S_WRD: begin
				o_addr = i_q[PW-1:0];
			end
			S_WTEST: begin
				k_addr  = idx_q;
				c_we    = !walk_go && !in_seg;
				c_waddr = idx_q;
				c_wdata = g_q;
			end
			S_EMIT: begin
				rd_en = i_q < n;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sel_q    <= 1'b0;
			i_q      <= '0;
			pend_s1  <= 1'b0;
			placed_q <= '0;
			posv_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (go) begin
						placed_q <= '0;
						posv_q   <= '0;
						i_q      <= '0;
						sel_q    <= 1'b0;
						state_q  <= S_FILL;
					end
				end
				S_FILL: begin
					pend_s1 <= rd_en;
					if (rd_en) begin
						i_q <= i_inc;
					end
					if (pend_s1) begin
						posv_q[o_rd] <= 1'b1;
					end
					if (!rd_en && !pend_s1) begin
						i_q     <= seg_s;
						state_q <= S_SEG;
					end
				end
				S_SEG: begin
					pend_s1 <= rd_en;
					if (rd_en) begin
						i_q <= i_inc;
					end
					if (pend_s1) begin
						placed_q[k_rd] <= 1'b1;
					end
					if (!rd_en && !pend_s1) begin
						i_q     <= seg_s;
						state_q <= S_WRD;
					end
				end
				S_WRD: begin
					if (i_q < seg_e) begin
						state_q <= S_WG;
					end else if (!sel_q) begin
						sel_q    <= 1'b1;
						placed_q <= '0;
						posv_q   <= '0;
						i_q      <= '0;
						state_q  <= S_FILL;
					end else begin
						i_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_WG: begin
					if (placed_q[o_rd]) begin
						i_q     <= i_inc;
						state_q <= S_WRD;
					end else begin
						state_q <= S_WTEST;
					end
				end
				S_WTEST: begin
					if (walk_go) begin
						state_q <= S_WK;
					end else begin
						placed_q[g_q] <= 1'b1;
						i_q           <= i_inc;
						state_q       <= S_WRD;
					end
				end
				S_WK: begin
					state_q <= S_WP;
				end
				S_WP: begin
					state_q <= S_WTEST;
				end
				S_EMIT: begin
					pend_s1 <= rd_en;
					if (rd_en) begin
						i_q <= i_inc;
					end
					if (!rd_en && !pend_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Walk datapath registers.
	always_ff @(posedge clk) begin
		idx_s1     <= i_q[PW-1:0];
		last_s1    <= i_inc == n;
		posv_bit_q <= posv_q[k_rd];
		if (state_q == S_WG) begin
			g_q     <= o_rd;
			idx_q   <= i_q[PW-1:0];
			steps_q <= '0;
		end else if (state_q == S_WP) begin
			idx_q   <= posv_bit_q ? pos_rd : '0;
			steps_q <= CW'(steps_q + 1'b1);
		end
	end

	assign stat.busy   = state_q != S_IDLE;
	assign stat.emit   = pend_s1 && (state_q == S_EMIT);
	assign stat.last   = last_s1;
	assign stat.gene_a = c1_rd;
	assign stat.gene_b = c2_rd;

	pmx_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_par_one (
		.clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(ld_gene_a),
		.raddr(p1_raddr), .rdata(p1_rd)
	);

	pmx_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_par_two (
		.clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(ld_gene_b),
		.raddr(p2_raddr), .rdata(p2_rd)
	);

	pmx_ram #(.WIDTH(PW), .DEPTH(GENE_SPACE)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rdata(pos_rd)
	);

	pmx_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_child_one (
		.clk(clk), .we(c_we && !sel_q), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c1_rd)
	);

	pmx_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_child_two (
		.clk(clk), .we(c_we && sel_q), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c2_rd)
	);

endmodule

/* hdl/pmx_chk.sv */
// ----------------------------------------------------------------------------
// PMX port checker
// Watches the ports of the crossover block for ordering of requests and results.
// ----------------------------------------------------------------------------
module pmx_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input pmx_pkg::pmx_req_t req,
	input logic              res_stb,
	input pmx_pkg::pmx_res_t res
);

	// Closing a block makes the block busy.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.last |=> busy)
		else $error("block not busy after closing request");

	// Results of one block come out back to back.
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && !res.final_res |=> res_stb)
		else $error("gap inside a result burst");

	// The final result ends the burst.
	a_final_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && res.final_res |=> !res_stb)
		else $error("result after final result");

	// A burst only begins after the block has been busy.
	a_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_stb) |-> $past(busy))
		else $error("result burst without preceding computation");

endmodule

bind partially_mapped_crossover pmx_chk u_pmx_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.req(req), .res_stb(res_stb), .res(res)
);
